// ===== sv/assert_macros.svh =====
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define HCBP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define HCBP_ASSERT_NEVER(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define HCBP_ASSERT(label, clk, rstn, prop, msg)
`define HCBP_ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ===== sv/hcbp_pkg.sv =====
`default_nettype none

package hcbp_pkg;

  localparam int unsigned CmdBits   = 2;
  localparam int unsigned SymBits   = 8;
  localparam int unsigned CodeBits  = 16;
  localparam int unsigned LenBits   = 5;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned AccBits   = 7;
  localparam int unsigned PendBits  = 3;

  localparam int unsigned MaxCodeLenDefault  = 16;
  localparam int unsigned SymbolCountDefault = 256;

  typedef enum logic [CmdBits-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CmdBits-1:0]  cmd;
    logic [SymBits-1:0]  symbol;
    logic [CodeBits-1:0] code_word;
    logic [LenBits-1:0]  code_length;
  } in_req_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last;
  } out_res_t;

  // table write, length already saturated
  typedef struct packed {
    logic                en;
    logic [SymBits-1:0]  symbol;
    logic [CodeBits-1:0] code_word;
    logic [LenBits-1:0]  code_length;
  } mem_wr_t;

  // registered table read
  typedef struct packed {
    logic                hit;
    logic [CodeBits-1:0] code_word;
    logic [LenBits-1:0]  code_length;
  } mem_rd_t;

endpackage

`default_nettype wire

// ===== sv/hcbp_in_if.sv =====
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/hcbp_out_if.sv =====
`default_nettype none

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic     valid;
  logic     ready;
  out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/huffman_code_bit_packer.sv =====
// huffman code bit packer: code table in a registered-read memory, 7-bit bit accumulator
// a result byte passes the registered table read and pack stage, then the output stage register
// throughput: one request per cycle unless a request with results waits on a busy
//   output stage; an encode that completes two bytes holds that stage until both are taken
// reset: asynchronous active low, clears all entry valid marks, accumulator and pipeline
// no clearing pass after reset, the block takes requests at once
`default_nettype none

`include "assert_macros.svh"

module huffman_code_bit_packer #(
  parameter int unsigned MaxCodeLen  = hcbp_pkg::MaxCodeLenDefault,
  parameter int unsigned SymbolCount = hcbp_pkg::SymbolCountDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  hcbp_in_if.sink   in_i,
  hcbp_out_if.source out_o
);
  import hcbp_pkg::*;

  // stored lengths never exceed the code word width
  localparam int unsigned LenLimit = (MaxCodeLen < CodeBits) ? MaxCodeLen : CodeBits;
  // pending bits plus the longest code
  localparam int unsigned CatBits  = AccBits + CodeBits;

  // ---------------------------------------------------------------------------
  // accept stage: loads write the table, every request reads it
  // ---------------------------------------------------------------------------
  logic    in_fire;
  logic    in_ready;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;

  assign in_fire = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_comb begin
    mem_wr.en          = in_fire && (cmd_e'(in_i.data.cmd) == CMD_LOAD);
    mem_wr.symbol      = in_i.data.symbol;
    mem_wr.code_word   = in_i.data.code_word;
    // long codes saturate to the length limit
    mem_wr.code_length = (in_i.data.code_length > LenBits'(LenLimit)) ?
                         LenBits'(LenLimit) : in_i.data.code_length;
  end

  // a request and a load are never accepted at the same edge, so a read
  // always sees every earlier write
  hcbp_code_mem #(
    .SymbolCount (SymbolCount)
  ) u_code_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (mem_wr),
    .rd_en_i  (in_fire),
    .rd_sym_i (in_i.data.symbol),
    .rd_o     (mem_rd)
  );

  // ---------------------------------------------------------------------------
  // pack stage: table data arrives, the accumulator is updated
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic [CmdBits-1:0] s1_cmd_q;
  logic [AccBits-1:0]  acc_q, acc_d;
  logic [PendBits-1:0] pend_q, pend_d;

  logic [CodeBits-1:0] code_mask;
  logic [CodeBits-1:0] code_bits;
  logic [CatBits-1:0]  cat;
  logic [LenBits-1:0]  total;
  logic [ByteBits-1:0] enc_hi;
  logic [ByteBits-1:0] enc_lo;
  logic [ByteBits-1:0] flush_byte;

  logic [1:0]          s1_nres;
  logic [ByteBits-1:0] s1_b0;
  logic [ByteBits-1:0] s1_b1;
  logic                s1_adv;

  // output stage, holds up to two bytes of one request
  logic                emit_valid_q;
  logic [ByteBits-1:0] emit_b0_q;
  logic [ByteBits-1:0] emit_b1_q;
  logic                emit_two_q;
  logic                emit_idx_q;
  logic                emit_last;
  logic                emit_done;

  // append the code bits under the pending ones
  assign code_mask = CodeBits'(((CodeBits+1)'(1) << mem_rd.code_length) - (CodeBits+1)'(1));
  assign code_bits = mem_rd.code_word & code_mask;
  assign cat       = (CatBits'(acc_q) << mem_rd.code_length) | CatBits'(code_bits);
  assign total     = LenBits'(pend_q) + mem_rd.code_length;

  // oldest complete byte, then the next one when sixteen or more bits are held
  assign enc_hi = ByteBits'(cat >> (total - LenBits'(ByteBits)));
  assign enc_lo = ByteBits'(cat >> (total - LenBits'(2 * ByteBits)));

  // pad the pending bits with zeros on the right
  assign flush_byte = ByteBits'({1'b0, acc_q} << (4'(ByteBits) - 4'(pend_q)));

  always_comb begin
    s1_nres = 2'd0;
    s1_b0   = enc_hi;
    s1_b1   = enc_lo;
    acc_d   = acc_q;
    pend_d  = pend_q;
    case (cmd_e'(s1_cmd_q))
      CMD_ENCODE: begin
        // unknown symbol leaves the accumulator alone
        if (mem_rd.hit) begin
          s1_nres = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
          pend_d  = total[PendBits-1:0];
          acc_d   = AccBits'(cat) &
                    AccBits'((8'd1 << total[PendBits-1:0]) - 8'd1);
        end
      end
      CMD_FLUSH: begin
        s1_nres = 2'd1;
        s1_b0   = flush_byte;
        acc_d   = '0;
        pend_d  = '0;
      end
      default: begin
        // loads are done at accept, unused command does nothing
      end
    endcase
  end

  assign emit_last = !emit_two_q || emit_idx_q;
  assign emit_done = emit_valid_q && out_o.ready && emit_last;

  // requests without results pass through regardless of the output stage
  assign s1_adv   = s1_valid_q && ((s1_nres == 2'd0) || !emit_valid_q || emit_done);
  assign in_ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= CMD_LOAD;
      acc_q      <= '0;
      pend_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_cmd_q   <= in_i.data.cmd;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_valid_q <= 1'b0;
      emit_two_q   <= 1'b0;
      emit_idx_q   <= 1'b0;
    end else begin
      if (s1_adv && (s1_nres != 2'd0)) begin
        emit_valid_q <= 1'b1;
        emit_two_q   <= (s1_nres == 2'd2);
        emit_idx_q   <= 1'b0;
      end else if (emit_done) begin
        emit_valid_q <= 1'b0;
      end else if (emit_valid_q && out_o.ready) begin
        emit_idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_nres != 2'd0)) begin
      emit_b0_q <= s1_b0;
      emit_b1_q <= s1_b1;
    end
  end

  assign out_o.valid         = emit_valid_q;
  assign out_o.data.out_byte = emit_idx_q ? emit_b1_q : emit_b0_q;
  assign out_o.data.last     = emit_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // accumulator bits above the pending count stay clear
  `HCBP_ASSERT_NEVER(a_acc_clean, clk_i, rst_ni, (acc_q >> pend_q) != AccBits'(0), "acc dirty")
  // a flush leaves nothing pending
  `HCBP_ASSERT(a_flush_clears, clk_i, rst_ni, (s1_adv && (cmd_e'(s1_cmd_q) == CMD_FLUSH)) |=> (pend_q == '0) && (acc_q == '0), "flush left bits")
  // input stalls only behind a busy output stage
  `HCBP_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready |-> (s1_valid_q && emit_valid_q), "stall without cause")

endmodule

`default_nettype wire

// ===== sv/hcbp_code_mem.sv =====
`default_nettype none

module hcbp_code_mem #(
  parameter int unsigned SymbolCount = hcbp_pkg::SymbolCountDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire hcbp_pkg::mem_wr_t wr_i,
  input  wire                    rd_en_i,
  input  wire [hcbp_pkg::SymBits-1:0] rd_sym_i,
  output hcbp_pkg::mem_rd_t      rd_o
);
  import hcbp_pkg::*;

  localparam int unsigned AddrBits = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;

  typedef struct packed {
    logic [CodeBits-1:0] code_word;
    logic [LenBits-1:0]  code_length;
  } entry_t;

  entry_t                 mem [SymbolCount];
  logic [SymbolCount-1:0] valid_q;
  logic                   hit_q;
  entry_t                 rd_data_q;

  logic [AddrBits-1:0] wr_addr;
  logic [AddrBits-1:0] rd_addr;
  logic                wr_in_range;
  logic                rd_in_range;

  assign wr_addr     = wr_i.symbol[AddrBits-1:0];
  assign rd_addr     = rd_sym_i[AddrBits-1:0];
  assign wr_in_range = {1'b0, wr_i.symbol} < (SymBits+1)'(SymbolCount);
  assign rd_in_range = {1'b0, rd_sym_i} < (SymBits+1)'(SymbolCount);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_addr] <= '{code_word: wr_i.code_word, code_length: wr_i.code_length};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_i.en && wr_in_range) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= rd_in_range && valid_q[rd_addr];
      end
    end
  end

  assign rd_o.hit         = hit_q;
  assign rd_o.code_word   = rd_data_q.code_word;
  assign rd_o.code_length = rd_data_q.code_length;

endmodule

`default_nettype wire

// ===== tb/huffman_code_bit_packer_tb.sv =====
`timescale 1ns / 100ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // cmd code that the block has no use for, it must be dropped silently
  localparam logic [CmdBits-1:0] CmdUnused = 2'd3;

  // longest code that a load can store, longer lengths saturate to it
  localparam int unsigned LenCap =
    (MaxCodeLenDefault < CodeBits) ? MaxCodeLenDefault : CodeBits;

  // cycles with no handshake on either channel before the run is declared hung
  localparam int unsigned QuietLimit = 3000;
  // settle time after the last byte, well above the time through the packer pipeline
  localparam int unsigned SettleCycles = 20;
  // useful random requests per idling phase
  localparam int unsigned PhaseRequests = 320;

  // shadow copy of the code table and bit accumulator, with the bytes still due
  class packer_shadow;
    logic [CodeBits-1:0] code_mem [SymbolCountDefault];
    logic [LenBits-1:0]  len_mem [SymbolCountDefault];
    bit                  valid_mem [SymbolCountDefault];
    logic [AccBits-1:0]  held_bits;
    logic [PendBits-1:0] held_count;
    out_res_t            due_bytes [$];
    int unsigned         mismatches;

    function new();
      held_bits  = '0;
      held_count = '0;
      mismatches = 0;
      foreach (valid_mem[i]) valid_mem[i] = 1'b0;
    endfunction

    // update the shadow state for one accepted request and queue its bytes
    function void note_request(in_req_t req);
      int unsigned clen;
      int unsigned acc;
      int unsigned total;
      int unsigned nbytes;
      out_res_t    res;
      case (req.cmd)
        CMD_LOAD: begin
          clen = (req.code_length > LenCap) ? LenCap : req.code_length;
          code_mem[req.symbol]  = req.code_word;
          len_mem[req.symbol]   = LenBits'(clen);
          valid_mem[req.symbol] = 1'b1;
        end
        CMD_ENCODE: begin
          if (valid_mem[req.symbol]) begin
            clen   = len_mem[req.symbol];
            acc    = (int'(held_bits) << clen)
                     | (int'(code_mem[req.symbol]) & ((32'h1 << clen) - 1));
            total  = held_count + clen;
            nbytes = total / 8;
            for (int k = 0; k < nbytes; k++) begin
              res.out_byte = 8'(acc >> (total - 8 * (k + 1)));
              res.last     = (k == nbytes - 1);
              due_bytes.push_back(res);
            end
            held_bits  = AccBits'(acc & ((32'h1 << (total % 8)) - 1));
            held_count = PendBits'(total % 8);
          end
        end
        CMD_FLUSH: begin
          res.out_byte = 8'(int'(held_bits) << (8 - held_count));
          res.last     = 1'b1;
          due_bytes.push_back(res);
          held_bits  = '0;
          held_count = '0;
        end
        default: begin
        end
      endcase
    endfunction

    // compare one delivered byte with the oldest one due
    function void check_byte(out_res_t got);
      out_res_t want;
      if (due_bytes.size() == 0) begin
        $display("%0t: byte %h last %b delivered, none expected",
                 $time, got.out_byte, got.last);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  packer_shadow shadow = new();

  // idling percentages of the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // symbols the stimulus has loaded, to tell useful encodes from no-ops
  bit sym_loaded [SymbolCountDefault];

  always #5 clk_i = ~clk_i;

  // every accepted request goes to the shadow packer
  always @(posedge clk_i) begin
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      shadow.note_request(in_if.data);
    end
  end

  // receiver: check each delivered byte, then pick the next ready
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        shadow.check_byte(out_if.data);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: a long run of cycles with no handshake on either side ends the test
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("huffman_code_bit_packer test failed");
    $finish;
  end

  function automatic in_req_t req_of(logic [CmdBits-1:0] cmd, int unsigned sym,
                                     int unsigned word, int unsigned len);
    in_req_t req;
    req.cmd         = cmd;
    req.symbol      = SymBits'(sym);
    req.code_word   = CodeBits'(word);
    req.code_length = LenBits'(len);
    return req;
  endfunction

  // offer one request after a random gap, return at the edge that takes it
  task automatic drive_request(in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (req.cmd == CMD_LOAD) sym_loaded[req.symbol] = 1'b1;
  endtask

  // sender holds off until every byte due has been delivered
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (shadow.due_bytes.size() != 0);
  endtask

  // hand-picked requests for the corner cases
  task automatic run_directed();
    in_req_t reqs [$];
    reqs.push_back(req_of(CMD_FLUSH, 0, 0, 0));           // flush with nothing pending
    reqs.push_back(req_of(CMD_ENCODE, 7, 16'hFFFF, 31));  // symbol with no entry
    reqs.push_back(req_of(CmdUnused, 255, 16'hFFFF, 31)); // unused command
    reqs.push_back(req_of(CMD_LOAD, 255, 16'hFFFF, 16));  // longest code, all ones
    reqs.push_back(req_of(CMD_LOAD, 0, 16'h0000, 16));    // longest code, all zeros
    reqs.push_back(req_of(CMD_LOAD, 1, 16'hABCD, 31));    // length saturates
    reqs.push_back(req_of(CMD_LOAD, 2, 16'hFFF5, 3));     // stray bits above length
    reqs.push_back(req_of(CMD_LOAD, 3, 16'hFFFF, 0));     // zero length entry
    reqs.push_back(req_of(CMD_LOAD, 4, 16'h0055, 7));
    reqs.push_back(req_of(CMD_ENCODE, 2, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 3, 0, 0));          // appends nothing
    reqs.push_back(req_of(CMD_ENCODE, 255, 0, 0));        // two bytes out
    reqs.push_back(req_of(CMD_ENCODE, 1, 0, 0));
    reqs.push_back(req_of(CMD_FLUSH, 0, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 0, 0, 0));          // two zero bytes
    reqs.push_back(req_of(CMD_ENCODE, 4, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 2, 0, 0));
    reqs.push_back(req_of(CMD_FLUSH, 0, 0, 0));
    reqs.push_back(req_of(CMD_FLUSH, 0, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 4, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 4, 0, 0));
    reqs.push_back(req_of(CMD_ENCODE, 255, 0, 0));
    reqs.push_back(req_of(CMD_FLUSH, 0, 0, 0));
    foreach (reqs[i]) drive_request(reqs[i]);
  endtask

  // mostly loads and encodes on a small symbol set so encodes hit the table,
  // with flushes, wide symbols, odd lengths and unused commands mixed in
  task automatic run_random(int unsigned useful_target);
    int unsigned useful;
    int unsigned pick;
    int unsigned sym;
    int unsigned len;
    in_req_t     req;
    useful = 0;
    while (useful < useful_target) begin
      pick = $urandom_range(99);
      sym  = ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255);
      len  = ($urandom_range(99) < 60) ? $urandom_range(16, 1) : $urandom_range(31);
      if (pick < 3) begin
        req = req_of(CmdUnused, sym, $urandom_range(65535), len);
      end else if (pick < 18) begin
        req = req_of(CMD_LOAD, sym, $urandom_range(65535), len);
      end else if (pick < 90) begin
        req = req_of(CMD_ENCODE, sym, $urandom_range(65535), len);
      end else begin
        req = req_of(CMD_FLUSH, sym, $urandom_range(65535), len);
      end
      // unused commands and encodes of unloaded symbols do nothing
      if (req.cmd != CmdUnused && !(req.cmd == CMD_ENCODE && !sym_loaded[sym])) begin
        useful++;
      end
      drive_request(req);
    end
  endtask

  initial begin
    foreach (sym_loaded[i]) sym_loaded[i] = 1'b0;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    hold_until_drained();

    // idling phases: none, sender gaps, receiver stalls, both
    send_idle_pct = 0;  recv_stall_pct = 0;
    run_random(PhaseRequests);
    hold_until_drained();
    send_idle_pct = 74; recv_stall_pct = 0;
    run_random(PhaseRequests);
    hold_until_drained();
    send_idle_pct = 0;  recv_stall_pct = 74;
    run_random(PhaseRequests);
    hold_until_drained();
    send_idle_pct = 32; recv_stall_pct = 32;
    run_random(PhaseRequests);
    hold_until_drained();

    // catch any stray byte that shows up late
    repeat (SettleCycles) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.due_bytes.size() == 0) begin
      $display("huffman_code_bit_packer test passed");
    end else begin
      $display("huffman_code_bit_packer test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hcbp_pkg.sv
sv/hcbp_in_if.sv
sv/hcbp_out_if.sv
sv/hcbp_code_mem.sv
sv/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_tb.sv
